// ===== design/ctfs_pkg.sv =====
package ctfs_pkg;

    localparam int unsigned AddrW   = 33;
    localparam int unsigned SectorW = 32;
    localparam int unsigned PhaseW  = 3;
    localparam int unsigned CfgIdxW = 1;

    localparam logic [PhaseW-1:0] LAST_PHASE = 3'd5;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_AREA_START  = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_AREA_LENGTH = 1'b1;

    // input command codes
    localparam logic CMD_START    = 1'b0;
    localparam logic CMD_RESPONSE = 1'b1;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_FOUND = 2'd1,
        KIND_NONE  = 2'd2
    } t_kind;

    typedef struct packed {
        logic              searching;
        logic [PhaseW-1:0] phase;
        logic [AddrW-1:0]  base;
        logic [AddrW-1:0]  probe;
        logic [AddrW-1:0]  end_addr;
    } t_search_state;

    typedef struct packed {
        logic               valid;
        t_kind              kind;
        logic [SectorW-1:0] addr;
    } t_result;

    function automatic logic [AddrW-1:0] stride_of(input logic [PhaseW-1:0] phase);
        logic [AddrW-1:0] s;
        case (phase)
            3'd0:    s = 33'd204800;
            3'd1:    s = 33'd20480;
            3'd2:    s = 33'd2048;
            3'd3:    s = 33'd204;
            3'd4:    s = 33'd20;
            default: s = 33'd1;
        endcase
        return s;
    endfunction

endpackage

// ===== design/ctfs_step.sv =====
module ctfs_step (
    input  ctfs_pkg::t_search_state      i_state,
    input  logic [ctfs_pkg::SectorW-1:0] i_area_start,
    input  logic [ctfs_pkg::SectorW-1:0] i_area_length,
    input  logic                         i_command,
    input  logic [7:0]                   i_hdr0,
    input  logic [7:0]                   i_hdr1,
    output ctfs_pkg::t_search_state      o_state,
    output ctfs_pkg::t_result            o_result
);

    logic [ctfs_pkg::PhaseW-1:0] phase;
    logic                        last;
    logic [ctfs_pkg::AddrW-1:0]  stride;
    logic [ctfs_pkg::AddrW-1:0]  start_ext;
    logic [ctfs_pkg::AddrW-1:0]  end_new;
    logic [ctfs_pkg::AddrW-1:0]  step_up;
    logic [ctfs_pkg::AddrW-1:0]  step_back;
    logic                        empty;

    assign phase     = (i_state.phase > ctfs_pkg::LAST_PHASE) ? ctfs_pkg::LAST_PHASE
                                                              : i_state.phase;
    assign last      = (phase == ctfs_pkg::LAST_PHASE);
    assign stride    = ctfs_pkg::stride_of(phase);
    assign start_ext = {1'b0, i_area_start};
    assign end_new   = start_ext + {10'd0, i_area_length[ctfs_pkg::SectorW-1:9]};
    assign step_up   = i_state.probe + stride;
    assign step_back = i_state.probe - stride;
    assign empty     = (i_hdr0 == 8'd0) && (i_hdr1 == 8'd0);

    always_comb begin
        o_state         = i_state;
        o_result.valid  = 1'b0;
        o_result.kind   = ctfs_pkg::KIND_READ;
        o_result.addr   = '0;
        if (i_command == ctfs_pkg::CMD_START) begin
            o_state.end_addr = end_new;
            o_state.phase    = '0;
            o_state.base     = start_ext;
            o_state.probe    = start_ext;
            o_result.valid   = 1'b1;
            if (start_ext >= end_new) begin
                o_state.searching = 1'b0;
                o_result.kind     = ctfs_pkg::KIND_NONE;
            end else begin
                o_state.searching = 1'b1;
                o_result.addr     = i_area_start;
            end
        end else if (i_state.searching) begin
            o_state.phase  = phase;
            o_result.valid = 1'b1;
            if (empty) begin
                if ((i_state.probe == i_state.base) || last) begin
                    o_state.searching = 1'b0;
                    o_result.kind     = ctfs_pkg::KIND_FOUND;
                    o_result.addr     = i_state.probe[ctfs_pkg::SectorW-1:0];
                end else begin
                    // hit past the first probe: back off one stride, refine
                    o_state.base  = step_back;
                    o_state.probe = step_back;
                    o_state.phase = phase + 3'd1;
                    o_result.addr = step_back[ctfs_pkg::SectorW-1:0];
                end
            end else begin
                o_state.probe = step_up;
                if (step_up < i_state.end_addr) begin
                    o_result.addr = step_up[ctfs_pkg::SectorW-1:0];
                end else if (last) begin
                    o_state.searching = 1'b0;
                    o_result.kind     = ctfs_pkg::KIND_NONE;
                end else begin
                    // ran off the end: next phase restarts from the same base
                    o_state.phase = phase + 3'd1;
                    o_state.probe = i_state.base;
                    o_result.addr = i_state.base[ctfs_pkg::SectorW-1:0];
                end
            end
        end
    end

endmodule

// ===== design/coarse_to_fine_empty_sector_search_core.sv =====
// Channel   Valid        Ready        Word
// input     i_in_valid   o_in_ready   i_command, i_header_first_byte, i_header_second_byte
// output    o_out_valid  i_out_ready  o_result_kind, o_sector_address
// config    i_cfg_we     (none)       i_cfg_idx, i_cfg_wdata
//
// Words pass through the input register, then one compare/stride add into the
// result register. One word is taken every cycle unless the output stalls; the
// state update shares the result register's stage, so consecutive words see fresh state.
// Reset is synchronous, active low, and clears control state and config.
// A stalled output holds the input register; a response while idle gives no word.
module coarse_to_fine_empty_sector_search_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ctfs_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [ctfs_pkg::SectorW-1:0] i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_command,
    input  logic [7:0]                   i_header_first_byte,
    input  logic [7:0]                   i_header_second_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_result_kind,
    output logic [ctfs_pkg::SectorW-1:0] o_sector_address
);

    logic [ctfs_pkg::SectorW-1:0] r_area_start;
    logic [ctfs_pkg::SectorW-1:0] r_area_length;

    logic                         r_in_valid;
    logic                         r_command;
    logic [7:0]                   r_hdr0;
    logic [7:0]                   r_hdr1;

    ctfs_pkg::t_search_state      r_state;
    ctfs_pkg::t_search_state      n_state;
    ctfs_pkg::t_result            n_result;

    logic                         r_out_valid;
    ctfs_pkg::t_kind              r_kind;
    logic [ctfs_pkg::SectorW-1:0] r_addr;

    logic                         advance;

    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_start  <= '0;
            r_area_length <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ctfs_pkg::CFG_AREA_START:  r_area_start  <= i_cfg_wdata;
                ctfs_pkg::CFG_AREA_LENGTH: r_area_length <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_command <= i_command;
            r_hdr0    <= i_header_first_byte;
            r_hdr1    <= i_header_second_byte;
        end
    end

    ctfs_step u_step (
        .i_state       (r_state),
        .i_area_start  (r_area_start),
        .i_area_length (r_area_length),
        .i_command     (r_command),
        .i_hdr0        (r_hdr0),
        .i_hdr1        (r_hdr1),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance && r_in_valid) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && n_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && n_result.valid) begin
            r_kind <= n_result.kind;
            r_addr <= n_result.addr;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_kind;
    assign o_sector_address = r_addr;

endmodule

// ===== design/ctfs_checker.sv =====
module ctfs_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [1:0]                   o_result_kind,
    input logic [ctfs_pkg::SectorW-1:0] o_sector_address
);

    // a held word keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_kind)
            && $stable(o_sector_address))
        else $error("output word changed while stalled");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_result_kind == ctfs_pkg::KIND_READ)
            || (o_result_kind == ctfs_pkg::KIND_FOUND)
            || (o_result_kind == ctfs_pkg::KIND_NONE))
        else $error("illegal result kind");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == ctfs_pkg::KIND_NONE) |-> o_sector_address == '0)
        else $error("not-found word carries an address");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // with the output slot free the input side never stalls
    a_ready_free: assert property (@(posedge i_clk)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

endmodule

bind coarse_to_fine_empty_sector_search_core ctfs_checker u_ctfs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_result_kind    (o_result_kind),
    .o_sector_address (o_sector_address)
);
